>>> rtl/core/sbrs_pkg.sv
package sbrs_pkg;

  // Table geometry.
  localparam int MAX_BOXES = 64;
  localparam int ADDR_W = $clog2(MAX_BOXES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int ID_W = 6;
  localparam int COORD_W = 12;
  localparam int REF_W = 10;
  localparam int WIN_W = 16;
  localparam int RESULT_LIMIT = 64;
  localparam int HIT_W = $clog2(RESULT_LIMIT + 1);

  // Operation codes.
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_RIGHT = 3'd2;
  localparam logic [2:0] OP_BELOW = 3'd3;
  localparam logic [2:0] OP_ABOVE = 3'd4;
  localparam logic [2:0] OP_INSIDE = 3'd5;
  localparam logic [2:0] OP_ROOT = 3'd6;
  localparam logic [2:0] OP_SCRIPT = 3'd7;

  // Register indexes.
  localparam logic CFG_REF_WIDTH = 1'b0;
  localparam logic CFG_REF_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] top_y;
    logic [COORD_W-1:0] right_s;
    logic [COORD_W-1:0] bottom_t;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    box_id;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] t;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

endpackage

>>> rtl/core/sbrs_table.sv
module sbrs_table
  import sbrs_pkg::*;
(
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [MAX_BOXES];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sorted_box_region_search.sv
// Load: reads and compares table entries from the end, shifting larger ones up, then writes the new
// entry; clear empties the table when accepted. Query: a binary search, then a scan of the entries,
// plus any wait of a match for the output register to free up.
// One operation at a time; the input stalls until the previous one has finished.
// Reset (synchronous, active high) empties the table and clears both registers.
module sorted_box_region_search
  import sbrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [REF_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS_RD = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_INS_WR = 3'd3;
  localparam logic [2:0] ST_BS = 3'd4;
  localparam logic [2:0] ST_BS_CMP = 3'd5;
  localparam logic [2:0] ST_SC = 3'd6;
  localparam logic [2:0] ST_SC_CMP = 3'd7;

  logic [2:0]         state;
  logic               fin;
  logic [REF_W-1:0]   ref_width;
  logic [REF_W-1:0]   ref_height;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [ADDR_W-1:0]  mid;
  logic [HIT_W-1:0]   hits;
  req_t               q;
  logic signed [WIN_W-1:0] sx, sy, ss, st;
  entry_t             pend;
  logic               have_pend;

  tbl_wr_t            wr;
  logic [ADDR_W-1:0]  raddr;
  entry_t             rdata;
  logic [CNT_W:0]     mid_sum;
  logic               slot_free;
  logic               accept;
  logic               rsp_load;

  logic signed [WIN_W-1:0] qx, qy, qs, qt, rx, ry;
  logic signed [WIN_W-1:0] bx, by, bs, bt;
  logic signed [WIN_W-1:0] wx, wy, ws, wt;
  logic                    hit;

  function automatic logic signed [WIN_W-1:0] ext(input logic [COORD_W-1:0] v);
    ext = $signed({{(WIN_W-COORD_W){1'b0}}, v});
  endfunction

  function automatic logic signed [WIN_W-1:0] smin(input logic signed [WIN_W-1:0] a,
                                                   input logic signed [WIN_W-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic logic signed [WIN_W-1:0] smax(input logic signed [WIN_W-1:0] a,
                                                   input logic signed [WIN_W-1:0] b);
    smax = (a > b) ? a : b;
  endfunction

  sbrs_table u_table (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_stall = (state != ST_IDLE) || fin;
  assign accept = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};

  // The output register takes a new result in this cycle.
  assign rsp_load = slot_free &&
                    ((state == ST_IDLE && fin) ||
                     (state == ST_SC_CMP && !(bx > ss) && hit && have_pend));

  // Signed views of the query, the reference size and the entry read.
  always_comb begin
    qx = ext(req.left_x);
    qy = ext(req.top_y);
    qs = ext(req.right_s);
    qt = ext(req.bottom_t);
    rx = $signed({{(WIN_W-REF_W){1'b0}}, ref_width});
    ry = $signed({{(WIN_W-REF_W){1'b0}}, ref_height});
    bx = ext(rdata.x);
    by = ext(rdata.y);
    bs = ext(rdata.s);
    bt = ext(rdata.t);
  end

  // Search window of an incoming query.
  always_comb begin
    unique case (req.op)
      OP_RIGHT: begin
        wx = smax(qx + 16'sd1, qs - (rx <<< 1));
        ws = qs + (rx <<< 3);
        wy = qy - ry;
        wt = qt + ry;
      end
      OP_BELOW: begin
        wx = qx - (rx <<< 1);
        ws = qs + (rx <<< 1);
        wy = smax(qt - ry, qy + 16'sd1);
        wt = qt + (ry <<< 1) + ry;
      end
      OP_ABOVE: begin
        wx = qx - (rx <<< 1);
        ws = qs + (rx <<< 1);
        wy = qy - (ry <<< 1) - ry;
        wt = smin(qy + ry, qt - 16'sd1);
      end
      OP_INSIDE: begin
        wx = qx + 16'sd1;
        ws = qs + rx;
        wy = qy + 16'sd1;
        wt = qt + ry;
      end
      OP_ROOT: begin
        wx = qx - (rx <<< 1);
        ws = smin(qx + (rx <<< 1), qs);
        wy = qy - ry;
        wt = smin(qy + (ry <<< 1), qt);
      end
      default: begin
        wx = qx - 16'sd1;
        ws = qx + 16'sd1;
        wy = qy - ry;
        wt = qt + ry;
      end
    endcase
  end

  // Mode test of the entry under scan.
  always_comb begin
    case (q.op)
      OP_BELOW: hit = (by <= st) && (by >= sy) && (bs <= ss);
      OP_ABOVE: hit = (bt <= st) && (bt >= sy) && (bs <= ss);
      default:  hit = (by <= st) && (bt >= sy);
    endcase
  end

  // Table read address.
  always_comb begin
    case (state) inside
      ST_INS_RD: raddr = ADDR_W'(pos - CNT_W'(1));
      ST_BS:     raddr = mid_sum[ADDR_W:1];
      ST_SC, ST_SC_CMP: raddr = lo[ADDR_W-1:0];
      default:   raddr = '0;
    endcase
  end

  // Table write port: shifting during insertion and the final placement.
  always_comb begin
    wr.en = 1'b0;
    wr.addr = pos[ADDR_W-1:0];
    wr.data = rdata;
    if (state == ST_INS_CMP && (bx > ext(q.left_x))) begin
      wr.en = 1'b1;
    end else if (state == ST_INS_WR) begin
      wr.en = 1'b1;
      wr.data = '{x: q.left_x, y: q.top_y, s: q.right_s, t: q.bottom_t,
                  id: count[ID_W-1:0]};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_width <= '0;
      ref_height <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_REF_WIDTH:  ref_width <= cfg_data;
        CFG_REF_HEIGHT: ref_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin <= 1'b0;
      count <= '0;
      have_pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (fin) begin
            // Close the query with the held match, or a no-match result.
            if (slot_free) begin
              rsp_valid <= 1'b1;
              rsp <= '{found: have_pend, box_id: have_pend ? pend.id : '0,
                       box_left: have_pend ? pend.x : '0,
                       box_top: have_pend ? pend.y : '0,
                       box_right: have_pend ? pend.s : '0,
                       box_bottom: have_pend ? pend.t : '0, last: 1'b1};
              have_pend <= 1'b0;
              fin <= 1'b0;
            end
          end else if (accept) begin
            q <= req;
            if (req.op == OP_CLEAR) begin
              count <= '0;
            end else if (req.op == OP_LOAD) begin
              pos <= count;
              if (count < CNT_W'(MAX_BOXES)) begin
                state <= (count == '0) ? ST_INS_WR : ST_INS_RD;
              end
            end else begin
              sx <= wx;
              sy <= wy;
              ss <= ws;
              st <= wt;
              lo <= '0;
              hi <= count;
              hits <= '0;
              have_pend <= 1'b0;
              state <= ST_BS;
            end
          end
        end
        ST_INS_RD: state <= ST_INS_CMP;
        ST_INS_CMP: begin
          if (bx > ext(q.left_x)) begin
            pos <= pos - CNT_W'(1);
            state <= (pos == CNT_W'(1)) ? ST_INS_WR : ST_INS_RD;
          end else begin
            state <= ST_INS_WR;
          end
        end
        ST_INS_WR: begin
          count <= count + CNT_W'(1);
          state <= ST_IDLE;
        end
        ST_BS: begin
          if (lo < hi) begin
            mid <= mid_sum[ADDR_W:1];
            state <= ST_BS_CMP;
          end else begin
            state <= ST_SC;
          end
        end
        ST_BS_CMP: begin
          if (sx <= bx) begin
            hi <= {1'b0, mid};
          end else begin
            lo <= {1'b0, mid} + CNT_W'(1);
          end
          state <= ST_BS;
        end
        ST_SC: begin
          if (lo < count && hits < HIT_W'(RESULT_LIMIT)) begin
            state <= ST_SC_CMP;
          end else begin
            state <= ST_IDLE;
            fin <= 1'b1;
          end
        end
        ST_SC_CMP: begin
          if (bx > ss) begin
            state <= ST_IDLE;
            fin <= 1'b1;
          end else if (!hit) begin
            lo <= lo + CNT_W'(1);
            state <= ST_SC;
          end else if (!have_pend || slot_free) begin
            // Pass the older match on; the new one waits to learn if it is last.
            if (have_pend) begin
              rsp_valid <= 1'b1;
              rsp <= '{found: 1'b1, box_id: pend.id, box_left: pend.x,
                       box_top: pend.y, box_right: pend.s, box_bottom: pend.t,
                       last: 1'b0};
            end
            pend <= rdata;
            have_pend <= 1'b1;
            hits <= hits + HIT_W'(1);
            case (q.op)
              OP_RIGHT: if (bx > ext(q.right_s)) ss <= smin(smin(bs, bx + rx), ss);
              OP_BELOW: if (by > ext(q.bottom_t)) st <= smin(smin(bt, by + ry), st);
              OP_ABOVE: if (bt < ext(q.top_y)) sy <= smax(smax(by, bt - ry), sy);
              default: ;
            endcase
            lo <= lo + CNT_W'(1);
            state <= ST_SC;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The table never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_BOXES))
    else $error("box count above capacity");

  // A no-match result always closes its query.
  assert property (@(posedge clk) disable iff (rst) rsp_valid && !rsp.found |-> rsp.last)
    else $error("no-match result without last");

  // A query transfer keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept && req.op != OP_CLEAR && req.op != OP_LOAD |=> req_stall)
    else $error("query transfer did not start a search");

  // The scan never holds more matches than the result limit.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SC_CMP |-> hits < HIT_W'(RESULT_LIMIT))
    else $error("scan past the result limit");

endmodule

>>> tb/tb_sorted_box_region_search.sv
`timescale 1ns / 1ps

module tb_sorted_box_region_search;
  import sbrs_pkg::*;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_we;
  logic             cfg_addr;
  logic [REF_W-1:0] cfg_data;

  sorted_box_region_search i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow copy of the box table and the reference size.
  entry_t      shadow_boxes[MAX_BOXES];
  int          shadow_count;
  int          win_rx;
  int          win_ry;

  req_t        pending_reqs[$];
  rsp_t        expected_hits[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          burst_weight;

  // Queue one request for the driver.
  task automatic add_req(input req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  // Apply one request to the shadow table and queue the results it causes.
  task automatic predict_request(input req_t r);
    int qx, qy, qs, qt, sx, sy, ss, st, lo, hi, m, p, n;
    int bx, by, bs, bt;
    bit hit;
    rsp_t o;
    qx = r.left_x; qy = r.top_y; qs = r.right_s; qt = r.bottom_t;
    n = 0;
    if (r.op == OP_CLEAR) begin
      shadow_count = 0;
      return;
    end
    if (r.op == OP_LOAD) begin
      if (shadow_count >= MAX_BOXES) return;
      p = shadow_count;
      while (p > 0 && int'(shadow_boxes[p-1].x) > qx) begin
        shadow_boxes[p] = shadow_boxes[p-1];
        p--;
      end
      shadow_boxes[p] = '{x: r.left_x, y: r.top_y, s: r.right_s, t: r.bottom_t,
                          id: shadow_count[ID_W-1:0]};
      shadow_count++;
      return;
    end
    case (r.op)
      OP_RIGHT: begin
        sx = (qx + 1 > qs - 2*win_rx) ? qx + 1 : qs - 2*win_rx;
        ss = qs + 8*win_rx; sy = qy - win_ry; st = qt + win_ry;
      end
      OP_BELOW: begin
        sx = qx - 2*win_rx; ss = qs + 2*win_rx;
        sy = (qt - win_ry > qy + 1) ? qt - win_ry : qy + 1; st = qt + 3*win_ry;
      end
      OP_ABOVE: begin
        sx = qx - 2*win_rx; ss = qs + 2*win_rx;
        sy = qy - 3*win_ry; st = (qy + win_ry < qt - 1) ? qy + win_ry : qt - 1;
      end
      OP_INSIDE: begin
        sx = qx + 1; ss = qs + win_rx; sy = qy + 1; st = qt + win_ry;
      end
      OP_ROOT: begin
        sx = qx - 2*win_rx; ss = (qx + 2*win_rx < qs) ? qx + 2*win_rx : qs;
        sy = qy - win_ry; st = (qy + 2*win_ry < qt) ? qy + 2*win_ry : qt;
      end
      default: begin
        sx = qx - 1; ss = qx + 1; sy = qy - win_ry; st = qt + win_ry;
      end
    endcase
    lo = 0; hi = shadow_count;
    while (lo < hi) begin
      m = (lo + hi) / 2;
      if (sx <= int'(shadow_boxes[m].x)) hi = m;
      else lo = m + 1;
    end
    for (int i = lo; i < shadow_count && int'(shadow_boxes[i].x) <= ss
         && n < RESULT_LIMIT; i++) begin
      bx = shadow_boxes[i].x; by = shadow_boxes[i].y;
      bs = shadow_boxes[i].s; bt = shadow_boxes[i].t;
      if (r.op == OP_BELOW) begin
        hit = by <= st && by >= sy && bs <= ss;
        if (hit && by > qt) begin
          if (bt < st) st = bt;
          if (by + win_ry < st) st = by + win_ry;
        end
      end else if (r.op == OP_ABOVE) begin
        hit = bt <= st && bt >= sy && bs <= ss;
        if (hit && bt < qy) begin
          if (by > sy) sy = by;
          if (bt - win_ry > sy) sy = bt - win_ry;
        end
      end else begin
        hit = by <= st && bt >= sy;
        if (hit && r.op == OP_RIGHT && bx > qs) begin
          if (bs < ss) ss = bs;
          if (bx + win_rx < ss) ss = bx + win_rx;
        end
      end
      if (hit) begin
        o = '{found: 1'b1, box_id: shadow_boxes[i].id, box_left: bx[COORD_W-1:0],
              box_top: by[COORD_W-1:0], box_right: bs[COORD_W-1:0],
              box_bottom: bt[COORD_W-1:0], last: 1'b0};
        expected_hits = {expected_hits, o};
        n++;
      end
    end
    if (n == 0) begin
      o = '0;
      o.last = 1'b1;
      expected_hits = {expected_hits, o};
    end else begin
      expected_hits[$].last = 1'b1;
    end
  endtask

  function automatic req_t make_req(input logic [2:0] op, input int x, input int y,
                                    input int s, input int t);
    req_t r;
    r.op = op;
    r.left_x = COORD_W'(x);
    r.top_y = COORD_W'(y);
    r.right_s = COORD_W'(s);
    r.bottom_t = COORD_W'(t);
    return r;
  endfunction

  // A box, mostly near a cluster so queries find neighbors, else anywhere.
  function automatic req_t rand_box(input logic [2:0] op);
    int x, y;
    if ($urandom_range(0, 9) == 0)
      return make_req(op, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
    x = $urandom_range(0, 600);
    y = $urandom_range(0, 600);
    return make_req(op, x, y, x + $urandom_range(0, 80), y + $urandom_range(0, 80));
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present the oldest pending request; idle at random between transfers.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        predict_request(req);
      end
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req       <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_hits.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: %p", rsp);
        end else begin
          if (rsp !== expected_hits[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p actual %p", expected_hits[0], rsp);
          end
          void'(expected_hits.pop_front());
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_ref(input logic addr, input int value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[REF_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_REF_WIDTH) win_rx = value;
    else win_ry = value;
  endtask

  // Limit on the whole run.
  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus.
  initial begin
    int rounds;
    logic [2:0] op;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_addr = CFG_REF_WIDTH; cfg_data = '0;
    shadow_count = 0; win_rx = 0; win_ry = 0;
    mismatch_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table query, extremes, every mode, ties, overflow.
    write_ref(CFG_REF_WIDTH, 10);
    write_ref(CFG_REF_HEIGHT, 10);
    add_req(make_req(OP_RIGHT, 0, 0, 0, 0));
    add_req(make_req(OP_LOAD, 4095, 4095, 4095, 4095));
    add_req(make_req(OP_LOAD, 0, 0, 0, 0));
    add_req(make_req(OP_LOAD, 100, 100, 120, 120));
    add_req(make_req(OP_LOAD, 100, 130, 110, 150));
    add_req(make_req(OP_LOAD, 125, 100, 140, 118));
    add_req(make_req(OP_LOAD, 100, 80, 115, 95));
    for (int o = OP_RIGHT; o <= OP_SCRIPT; o++)
      add_req(make_req(o[2:0], 100, 100, 120, 120));
    add_req(make_req(OP_SCRIPT, 4095, 4095, 4095, 4095));
    add_req(make_req(OP_ROOT, 0, 0, 4095, 4095));
    add_req(make_req(OP_CLEAR, 0, 0, 0, 0));
    add_req(make_req(OP_INSIDE, 0, 0, 4095, 4095));
    wait_drained();

    // Full table of overlapping boxes, overflow drop, and a 64-match query.
    write_ref(CFG_REF_WIDTH, 1023);
    write_ref(CFG_REF_HEIGHT, 1023);
    for (int i = 0; i < 66; i++)
      add_req(make_req(OP_LOAD, 10 + (i % 5), 50, 20, 60));
    add_req(make_req(OP_SCRIPT, 12, 50, 20, 60));
    add_req(make_req(OP_INSIDE, 0, 0, 4095, 4095));
    add_req(make_req(OP_ROOT, 3000, 50, 4095, 60));
    add_req(make_req(OP_CLEAR, 0, 0, 0, 0));
    wait_drained();

    // Random phases with differing idling and reference sizes.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      write_ref(CFG_REF_WIDTH, phase == 0 ? 0 : (phase == 5 ? 1023 : $urandom_range(0, 60)));
      write_ref(CFG_REF_HEIGHT, phase == 0 ? 1023 : (phase == 5 ? 0 : $urandom_range(0, 60)));
      add_req(make_req(OP_CLEAR, 0, 0, 0, 0));
      rounds = $urandom_range(6, 10);
      for (int i = 0; i < rounds; i++)
        add_req(rand_box(OP_LOAD));
      for (int i = 0; i < 12; i++) begin
        burst_weight = $urandom_range(0, 9);
        if (burst_weight == 0) op = OP_LOAD;
        else if (burst_weight == 1) op = $urandom_range(0, 1) ? OP_LOAD : OP_CLEAR;
        else op = 3'($urandom_range(OP_RIGHT, OP_SCRIPT));
        add_req(rand_box(op));
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sorted_box_region_search.f
rtl/core/sbrs_pkg.sv
rtl/core/sbrs_table.sv
rtl/core/sorted_box_region_search.sv
tb/tb_sorted_box_region_search.sv
